>>> rtl/core/xcve_pkg.sv
`timescale 1ns / 1ps

package xcve_pkg;

    // Key bytes 43 37 92 A4 38 F1 2B in position order, position zero lowest.
    localparam logic [55:0] KEY_RESET = 56'h2B_F1_38_A4_92_37_43;
    localparam logic [2:0]  KEY_LAST_POS = 3'd6;

    localparam logic OP_RAW    = 1'b0;
    localparam logic OP_VARINT = 1'b1;

    typedef logic [2:0] key_pos_t;

    // Control from the top level to the key unit.
    typedef struct packed {
        logic restart;   // new record: position back to zero
        logic step;      // a byte has been emitted: advance position
        logic cfg_we;
    } key_ctrl_t;

    // Status from the group shifter to the top level.
    typedef struct packed {
        logic       busy;
        logic       is_last;
        logic [7:0] group;
    } grp_stat_t;

endpackage

>>> rtl/core/xcve_if.sv
`timescale 1ns / 1ps

interface xcve_item_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] value;
    logic        new_record;

    modport source (output valid, output op, output value, output new_record, input ready);
    modport sink (input valid, input op, input value, input new_record, output ready);
endinterface

interface xcve_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

>>> rtl/core/xcve_group_shifter.sv
`timescale 1ns / 1ps

module xcve_group_shifter
    import xcve_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic        load_op,
    input  logic [31:0] load_value,
    input  logic        advance,
    output grp_stat_t   stat
);

    logic        busy_reg;
    logic        busy_next;
    logic        op_reg;
    logic [31:0] val_reg;
    logic [31:0] val_next;
    logic        more;

    // For a varint, more groups follow while any bit above the low seven is set.
    assign more = (op_reg == OP_VARINT) && (|val_reg[31:7]);

    assign stat.busy    = busy_reg;
    assign stat.is_last = !more;
    assign stat.group   = (op_reg == OP_RAW) ? val_reg[7:0] : {more, val_reg[6:0]};

    always_comb
    begin
        busy_next = busy_reg;
        val_next  = val_reg;
        if (load)
        begin
            busy_next = 1'b1;
            val_next  = load_value;
        end
        else if (advance)
        begin
            busy_next = more;
            val_next  = {7'd0, val_reg[31:7]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        if (load)
        begin
            op_reg <= load_op;
        end
    end

endmodule

>>> rtl/core/xcve_key_unit.sv
`timescale 1ns / 1ps

module xcve_key_unit
    import xcve_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  key_ctrl_t   ctrl,
    input  logic [55:0] cfg_data,
    output logic [7:0]  key_byte,
    output key_pos_t    pos
);

    logic [55:0] key_reg;
    key_pos_t    pos_reg;
    key_pos_t    pos_next;

    assign pos = pos_reg;

    always_comb
    begin
        unique case (pos_reg)
            3'd0:    key_byte = key_reg[7:0];
            3'd1:    key_byte = key_reg[15:8];
            3'd2:    key_byte = key_reg[23:16];
            3'd3:    key_byte = key_reg[31:24];
            3'd4:    key_byte = key_reg[39:32];
            3'd5:    key_byte = key_reg[47:40];
            3'd6:    key_byte = key_reg[55:48];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        priority if (ctrl.restart)
        begin
            pos_next = 3'd0;
        end
        else if (ctrl.step)
        begin
            pos_next = (pos_reg >= KEY_LAST_POS) ? 3'd0 : pos_reg + 3'd1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= KEY_RESET;
            pos_reg <= 3'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (ctrl.cfg_we)
            begin
                key_reg <= cfg_data;
            end
        end
    end

endmodule

>>> rtl/core/xor_cycle_varint_encoder_unit.sv
`timescale 1ns / 1ps

// Channel   Dir   Beat contents                    Handshake
// item      in    op, value[31:0], new_record      valid / ready
// result    out   out_byte[7:0], last              valid / ready
// key       in    key_wdata[55:0]                  key_we, no back-pressure
//
// A raw-byte item yields one byte and a varint item one byte per 7-bit group,
// so one to five bytes; the group shifter emits one byte per cycle when not stalled.
// The next item is taken in the cycle its predecessor's last byte leaves the shifter.
// Reset clears the position counter, loads the default key and empties both stages.
// A stall on the result side holds the output register and freezes the shifter.

module xor_cycle_varint_encoder_unit
    import xcve_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    xcve_item_if.sink    item,
    xcve_byte_if.source  result,
    input  logic         key_we,
    input  logic [55:0]  key_wdata
);

    grp_stat_t  grp;
    key_ctrl_t  kctl;
    logic [7:0] key_byte;
    key_pos_t   key_pos;
    logic       accept;
    logic       advance;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    // The shifter advances whenever it holds a group and the output register
    // is empty or being emptied in this cycle.
    assign advance = grp.busy && (!out_valid_reg || result.ready);

    // A new item may enter as soon as the current one's final byte moves on.
    assign item.ready = !grp.busy || (advance && grp.is_last);
    assign accept     = item.valid && item.ready;

    assign kctl.restart = accept && item.new_record;
    assign kctl.step    = advance;
    assign kctl.cfg_we  = key_we;

    xcve_group_shifter u_shifter (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .load_op    (item.op),
        .load_value (item.value),
        .advance    (advance),
        .stat       (grp)
    );

    xcve_key_unit u_key (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (kctl),
        .cfg_data (key_wdata),
        .key_byte (key_byte),
        .pos      (key_pos)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the output register; the key byte is that of the current position.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= grp.group ^ key_byte;
            out_last_reg <= grp.is_last;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.last     = out_last_reg;

    // The key position counts modulo seven.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        key_pos <= KEY_LAST_POS)
        else $error("key position out of range");

    // An accepted item always leaves the shifter with work to do.
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> grp.busy)
        else $error("shifter idle after accept");

    // A busy shifter with a free output register produces a byte next cycle.
    a_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (grp.busy && !out_valid_reg) |=> out_valid_reg)
        else $error("shifter failed to emit a byte");

    // A new record restarts the key cycle at position zero.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        kctl.restart |=> (key_pos == 3'd0))
        else $error("key position not restarted");

endmodule

>>> tb/xor_cycle_varint_encoder_unit_test.sv
`timescale 1ns / 1ps

module xor_cycle_varint_encoder_unit_test
    import xcve_pkg::*;
();

    // Ample room for every phase at its worst: about 320 items of five bytes each,
    // long random stalls and the deliberate hold-off on the result side.
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int DRAIN_CYCLES = 20;

    // One expected beat on the result channel.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } coded_byte_t;

    // Keeps its own copy of the key and the position in the record, and a queue
    // of the bytes that the encoder still owes.
    class xor_stream_board;
        logic [55:0] key;
        logic [2:0]  position;
        coded_byte_t owed_bytes[$];
        int          errors;

        function new();
            key = KEY_RESET;
            position = '0;
            errors = 0;
        endfunction

        function void set_key(logic [55:0] k);
            key = k;
        endfunction

        // XORs one byte with the key byte of the current position and moves on.
        function logic [7:0] scramble(logic [7:0] plain);
            logic [7:0] k;
            k = key[position * 8 +: 8];
            position = (position == KEY_LAST_POS) ? 3'd0 : position + 3'd1;
            return plain ^ k;
        endfunction

        function void owe(logic [7:0] plain, logic last);
            coded_byte_t b;
            b.data = scramble(plain);
            b.last = last;
            owed_bytes = {owed_bytes, b};
        endfunction

        function void note_item(logic op, logic [31:0] value, logic new_record);
            logic [31:0] rest;
            if (new_record)
                position = '0;
            if (op == OP_RAW)
            begin
                owe(value[7:0], 1'b1);
            end
            else
            begin
                rest = value;
                while (rest > 32'd127)
                begin
                    owe({1'b1, rest[6:0]}, 1'b0);
                    rest = rest >> 7;
                end
                owe(rest[7:0], 1'b1);
            end
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            coded_byte_t want;
            if (owed_bytes.size() == 0)
            begin
                $error("unexpected beat: out_byte 0x%02h last %0d", data, last);
                errors++;
                return;
            end
            want = owed_bytes.pop_front();
            if (data !== want.data)
            begin
                $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, data);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        key_we;
    logic [55:0] key_wdata;

    xcve_item_if item_ch();
    xcve_byte_if byte_ch();

    xor_cycle_varint_encoder_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (byte_ch),
        .key_we    (key_we),
        .key_wdata (key_wdata)
    );

    xor_stream_board board = new();

    // Per-phase idling percentages, one for the sender and one for the receiver.
    int send_idle;
    int recv_stall;
    // Set by the main sequence to ask the receiver for one long hold-off.
    bit hold_request;
    int hold_left;
    int cycle_count;

    always #5 clk = ~clk;

    // Watchdog: a hung handshake must not keep the run going for ever.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver decides its ready at the falling edge, so the encoder sees a
    // settled value at the next rising edge. A long hold-off, once asked for,
    // is counted down here and overrides the random stalls.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            byte_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES - 1;
            byte_ch.ready <= 1'b0;
        end
        else
        begin
            byte_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // Result beats are taken at the rising edge, where both valid and ready are
    // the values that the edge itself sees.
    always @(posedge clk)
    begin
        if (rst_n && byte_ch.valid && byte_ch.ready)
            board.check_byte(byte_ch.out_byte, byte_ch.last);
    end

    // Offers one item and returns at the falling edge after it was accepted.
    // Valid is assigned at most once per falling edge, so a run of back-to-back
    // items keeps it high without a glitch.
    task automatic send_item(input logic op, input logic [31:0] value, input logic new_record);
        while ($urandom_range(0, 99) < send_idle)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.op         <= op;
        item_ch.value      <= value;
        item_ch.new_record <= new_record;
        do
            @(posedge clk);
        while (!item_ch.ready);
        board.note_item(op, value, new_record);
        @(negedge clk);
    endtask

    // Mostly varints, with the value's length drawn first so that every byte
    // count turns up often; a quarter of the varint values are plain 32-bit noise.
    task automatic send_random_item();
        logic        op;
        logic [31:0] value;
        logic        new_record;
        int          width;
        op = ($urandom_range(0, 2) != 0) ? OP_VARINT : OP_RAW;
        new_record = ($urandom_range(0, 3) == 0);
        value = $urandom;
        if (op == OP_VARINT && $urandom_range(0, 3) != 0)
        begin
            width = $urandom_range(0, 32);
            value = value >> (32 - width);
        end
        send_item(op, value, new_record);
    endtask

    // Lets every owed byte come out, then a few quiet cycles before the key may change.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (board.owed_bytes.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_key(input logic [55:0] k);
        key_wdata <= k;
        key_we    <= 1'b1;
        @(negedge clk);
        key_we    <= 1'b0;
        board.set_key(k);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input logic [55:0] k);
        settle();
        write_key(k);
        send_idle = idle_pct;
        recv_stall = stall_pct;
        repeat (ITEMS_PER_PHASE) send_random_item();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        key_we = 1'b0;
        key_wdata = '0;
        item_ch.valid = 1'b0;
        item_ch.op = OP_RAW;
        item_ch.value = '0;
        item_ch.new_record = 1'b0;
        byte_ch.ready = 1'b0;
        send_idle = 0;
        recv_stall = 0;
        hold_request = 1'b0;
        hold_left = 0;
        cycle_count = 0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset key with no idling: raw bytes at both
        // ends and with junk in the upper bits, which must be dropped, then
        // varints on each side of every group boundary up to the five-byte
        // maximum. The run of multi-byte items walks the position past the
        // wrap from six to zero, and a few new records pull it back mid-way.
        send_item(OP_RAW,    32'h0000_0000, 1'b1);
        send_item(OP_RAW,    32'h0000_00FF, 1'b0);
        send_item(OP_RAW,    32'hDEAD_BE5A, 1'b0);
        send_item(OP_RAW,    32'hFFFF_FF00, 1'b0);
        send_item(OP_VARINT, 32'd0,         1'b1);
        send_item(OP_VARINT, 32'd1,         1'b0);
        send_item(OP_VARINT, 32'd127,       1'b0);
        send_item(OP_VARINT, 32'd128,       1'b0);
        send_item(OP_VARINT, 32'd16383,     1'b0);
        send_item(OP_VARINT, 32'd16384,     1'b0);
        send_item(OP_VARINT, 32'd2097151,   1'b1);
        send_item(OP_VARINT, 32'd2097152,   1'b0);
        send_item(OP_VARINT, 32'd268435455, 1'b0);
        send_item(OP_VARINT, 32'd268435456, 1'b1);
        send_item(OP_VARINT, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_VARINT, 32'h8000_0000, 1'b0);
        send_item(OP_RAW,    32'h0000_00A5, 1'b1);
        send_item(OP_VARINT, 32'h5555_5555, 1'b0);
        send_item(OP_VARINT, 32'hAAAA_AAAA, 1'b0);

        // Random phases, each under a different key, the extremes among them.
        run_phase(0,  0,  56'h00_0000_0000_0000);
        run_phase(50, 0,  56'hFF_FFFF_FFFF_FFFF);
        run_phase(0,  50, 56'({$urandom, $urandom}));
        run_phase(37, 37, 56'({$urandom, $urandom}));

        // Back-pressure: the receiver holds off for a long stretch while the
        // sender keeps offering beats with no gaps, so the encoder fills up and
        // has to drop its item ready until the hold-off ends.
        settle();
        write_key(56'({$urandom, $urandom}));
        send_idle = 0;
        recv_stall = 0;
        hold_request = 1'b1;
        repeat (ITEMS_PER_PHASE) send_random_item();

        item_ch.valid <= 1'b0;
        while (board.owed_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
